// ===== sv/chp_pkg.sv =====
// ----------------------------------------------------------------------------
// chp_pkg
// shared types, codes and constants of the hex cheat code parser
// ----------------------------------------------------------------------------
package chp_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [3:0]  TOKEN_DIGITS     = 4'd8;
	localparam logic [3:0]  COUNT_SAT        = 4'd9;
	localparam logic [7:0]  TYPE_WRITE       = 8'h01;
	localparam logic [15:0] ADDR_LOW_LIMIT   = 16'h8000;
	localparam logic [15:0] ADDR_HOLE_START  = 16'hFEA0;
	localparam logic [15:0] ADDR_HOLE_END    = 16'hFF00;
	localparam logic [15:0] ADDR_REFUSED_TOP = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_WRITE       = 3'd0,
		ST_END_OK      = 3'd1,
		ST_BAD_LENGTH  = 3'd2,
		ST_BAD_TYPE    = 3'd3,
		ST_BAD_ADDRESS = 3'd4,
		ST_BAD_CHAR    = 3'd5,
		ST_EMPTY       = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		OP_DIGIT = 2'd0,
		OP_SEP   = 2'd1,
		OP_BAD   = 2'd2,
		OP_END   = 2'd3
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [3:0] nibble;
	} op_t;

endpackage

// ===== sv/chp_if.sv =====
// ----------------------------------------------------------------------------
// chp_in_if / chp_out_if
// valid/ready channels for character beats and result beats
// ----------------------------------------------------------------------------
interface chp_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] character;

	modport source (output valid, output kind, output character, input ready);
	modport sink (input valid, input kind, input character, output ready);
endinterface

interface chp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] target_address;
	logic [7:0]  write_value;
	logic        last;

	modport source (output valid, output status, output target_address,
		output write_value, output last, input ready);
	modport sink (input valid, input status, input target_address,
		input write_value, input last, output ready);
endinterface

// ===== sv/chp_front.sv =====
// ----------------------------------------------------------------------------
// chp_front
// accepts character beats and classifies them into parser operations
// ----------------------------------------------------------------------------
module chp_front import chp_pkg::*; (
	chp_in_if.sink   in_ch,
	input  logic     full,
	output logic     push,
	output op_t      op
);

	logic       is_digit;
	logic [3:0] nib;
	logic       is_sep;
	logic       is_hyphen;
	logic [7:0] c;

	assign c = in_ch.character;

	always_comb begin
		is_digit = 1'b1;
		nib      = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			nib = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			nib = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			nib = 4'(c - 8'h37);
		end else begin
			is_digit = 1'b0;
		end
	end

	assign is_sep = (c == 8'h2B) || (c == 8'h2C) || (c == 8'h20) ||
		(c >= 8'h09 && c <= 8'h0D);
	assign is_hyphen = (c == 8'h2D);

	always_comb begin
		op.nibble = nib;
		if (in_ch.kind) begin
			op.kind = OP_END;
		end else if (is_digit) begin
			op.kind = OP_DIGIT;
		end else if (is_sep) begin
			op.kind = OP_SEP;
		end else begin
			op.kind = OP_BAD;
		end
	end

	// hyphens have no effect and are dropped here
	assign in_ch.ready = !full;
	assign push = in_ch.valid && !full && !(!in_ch.kind && is_hyphen);

endmodule

// ===== sv/chp_fifo.sv =====
// ----------------------------------------------------------------------------
// chp_fifo
// short operation queue between the front and back parts
// ----------------------------------------------------------------------------
module chp_fifo import chp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic avail,
	output op_t  pop_op
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	op_t           mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full   = (cnt_q == FULL_CNT);
	assign avail  = (cnt_q != '0);
	assign pop_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !avail)) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT) else $error("queue count out of range");
`endif

endmodule

// ===== sv/chp_back.sv =====
// ----------------------------------------------------------------------------
// chp_back
// token state, token checks and the result output register
// ----------------------------------------------------------------------------
module chp_back import chp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      avail,
	input  op_t       op,
	output logic      pop,
	chp_out_if.source out_ch
);

	typedef struct packed {
		status_t     status;
		logic [15:0] addr;
		logic [7:0]  value;
	} check_t;

	function automatic check_t check_token(input logic [31:0] tok, input logic [3:0] cnt);
		check_t      r;
		logic [15:0] a;
		a       = {tok[7:0], tok[15:8]};
		r.status = ST_WRITE;
		r.addr   = a;
		r.value  = tok[23:16];
		if (cnt != TOKEN_DIGITS) begin
			r.status = ST_BAD_LENGTH;
		end else if (tok[31:24] != TYPE_WRITE) begin
			r.status = ST_BAD_TYPE;
		end else if (a < ADDR_LOW_LIMIT || (a >= ADDR_HOLE_START && a < ADDR_HOLE_END) ||
			a == ADDR_REFUSED_TOP) begin
			r.status = ST_BAD_ADDRESS;
		end
		if (r.status != ST_WRITE) begin
			r.addr  = '0;
			r.value = '0;
		end
		return r;
	endfunction

	logic [31:0] token_q;
	logic [3:0]  count_q;
	logic        any_q;
	logic        skip_q;
	logic        out_valid_q;
	status_t     status_q;
	logic [15:0] addr_q;
	logic [7:0]  value_q;
	logic        last_q;

	logic [31:0] token_d;
	logic [3:0]  count_d;
	logic        any_d;
	logic        skip_d;
	logic        emit;
	check_t      res;
	logic        res_last;
	check_t      chk;

	assign pop = avail && (!out_valid_q || out_ch.ready);
	assign chk = check_token(token_q, count_q);

	always_comb begin
		token_d  = token_q;
		count_d  = count_q;
		any_d    = any_q;
		skip_d   = skip_q;
		emit     = 1'b0;
		res      = chk;
		res_last = 1'b1;
		case (op.kind)
			OP_END: begin
				emit = !skip_q;
				if (count_q == '0) begin
					res.status = any_q ? ST_END_OK : ST_EMPTY;
					res.addr   = '0;
					res.value  = '0;
				end
				token_d = '0;
				count_d = '0;
				any_d   = 1'b0;
				skip_d  = 1'b0;
			end
			OP_DIGIT: begin
				if (!skip_q) begin
					token_d = {token_q[27:0], op.nibble};
					if (count_q != COUNT_SAT) begin
						count_d = count_q + 1'b1;
					end
				end
			end
			OP_SEP: begin
				if (!skip_q && count_q != '0) begin
					emit    = 1'b1;
					token_d = '0;
					count_d = '0;
					if (chk.status == ST_WRITE) begin
						any_d    = 1'b1;
						res_last = 1'b0;
					end else begin
						skip_d = 1'b1;
					end
				end
			end
			OP_BAD: begin
				if (!skip_q) begin
					emit       = 1'b1;
					skip_d     = 1'b1;
					res.status = ST_BAD_CHAR;
					res.addr   = '0;
					res.value  = '0;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q     <= '0;
			count_q     <= '0;
			any_q       <= 1'b0;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				token_q <= token_d;
				count_q <= count_d;
				any_q   <= any_d;
				skip_q  <= skip_d;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			status_q <= res.status;
			addr_q   <= res.addr;
			value_q  <= res.value;
			last_q   <= res_last;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.status         = status_q;
	assign out_ch.target_address = addr_q;
	assign out_ch.write_value    = value_q;
	assign out_ch.last           = last_q;

`ifndef SYNTHESIS
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_SAT) else $error("digit count beyond saturation");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && op.kind == OP_END) |=> (count_q == '0 && !skip_q && !any_q))
		else $error("end of code left state behind");
	a_no_emit_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && skip_q && op.kind != OP_END) |=> !($past(emit)))
		else $error("result emitted while skipping to end");
	a_write_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_WRITE) |-> last_q)
		else $error("error or end result without last");
`endif

endmodule

// ===== sv/cheat_code_hex_parser.sv =====
// ----------------------------------------------------------------------------
// cheat_code_hex_parser
// parses hex cheat codes of type 01 into memory write beats
// ----------------------------------------------------------------------------
// Takes one character beat per cycle while the queue is not full; gives at
// most one result beat per character. A beat passes the classifying front
// end into a short queue; the token engine takes one queued operation per
// cycle while the output register is empty or taken, and a result passes
// the queue and then the output register. With the output ready the rate is
// one beat per cycle. Hyphens are dropped at the front end, never queued.
// ----------------------------------------------------------------------------
module cheat_code_hex_parser import chp_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	chp_in_if.sink    in_ch,
	chp_out_if.source out_ch
);

	logic full;
	logic push;
	op_t  push_op;
	logic pop;
	logic avail;
	op_t  pop_op;

	chp_front u_front (
		.in_ch (in_ch),
		.full  (full),
		.push  (push),
		.op    (push_op)
	);

	chp_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (full),
		.pop     (pop),
		.avail   (avail),
		.pop_op  (pop_op)
	);

	chp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (avail),
		.op     (pop_op),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule
